// ===== hdl/remote_key_repeat_filter_defines.svh =====
// Assertion macros for the remote key repeat filter checker.
// Uses clk and arst_n of the scope in which a macro is expanded.
`ifndef REMOTE_KEY_REPEAT_FILTER_DEFINES_SVH
`define REMOTE_KEY_REPEAT_FILTER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RKRF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rkrf assertion failed");

// Next-cycle implication, disabled during reset
`define RKRF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rkrf assertion failed");

`endif

// ===== hdl/rkrf_pkg.sv =====
// Package of the remote key repeat filter: widths, constants, register codes, command type.
// No dependencies.
`default_nettype none

package rkrf_pkg;

	localparam int KEY_W   = 32;
	localparam int STAMP_W = 64;
	localparam int CFG_W   = 16;
	// ms threshold scaled to ns: 16 bit times 1e6 fits in 36 bits
	localparam int THR_W   = 36;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;
	localparam int REG_LSB = 2;

	localparam int QUEUE_DEPTH_DEFAULT = 2;

	localparam logic [THR_W-1:0] NS_PER_MS      = THR_W'(1000000);
	localparam logic [CFG_W-1:0] DELAY_RESET    = CFG_W'(300);
	localparam logic [CFG_W-1:0] INTERVAL_RESET = CFG_W'(100);
	localparam logic [THR_W-1:0] THR_DELAY_RESET    = THR_W'(300 * 1000000);
	localparam logic [THR_W-1:0] THR_INTERVAL_RESET = THR_W'(100 * 1000000);

	typedef enum logic [0:0] {
		REG_DELAY    = 1'b0,
		REG_INTERVAL = 1'b1
	} reg_idx_t;

	// Work for the back end: an optional release, then an optional key event
	typedef struct packed {
		logic             has_rel;
		logic [KEY_W-1:0] rel_key;
		logic             has_ev;
		logic [KEY_W-1:0] ev_key;
		logic             ev_rep;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hdl/rkrf_in_if.sv =====
// Input channel of the remote key repeat filter: scancode or stream-end transactions.
// Depends on rkrf_pkg.
`default_nettype none

interface rkrf_in_if import rkrf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               op;
	logic [KEY_W-1:0]   key_code;
	logic               toggle_bit;
	logic               repeat_bit;
	logic [STAMP_W-1:0] stamp_ns;

	modport source (output valid, op, key_code, toggle_bit, repeat_bit, stamp_ns, input ready);
	modport sink (input valid, op, key_code, toggle_bit, repeat_bit, stamp_ns, output ready);
endinterface

`default_nettype wire

// ===== hdl/rkrf_out_if.sv =====
// Output channel of the remote key repeat filter: key press, repeat and release transactions.
// Depends on rkrf_pkg.
`default_nettype none

interface rkrf_out_if import rkrf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] out_key;
	logic             is_repeat;
	logic             is_release;
	logic             last_of_run;

	modport source (output valid, out_key, is_repeat, is_release, last_of_run, input ready);
	modport sink (input valid, out_key, is_repeat, is_release, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hdl/rkrf_cfg.sv =====
// APB register file: repeat delay and repeat interval, plus their thresholds in ns.
// Depends on rkrf_pkg.
`default_nettype none

module rkrf_cfg import rkrf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output logic      [THR_W-1:0]  thr_delay,
	output logic      [THR_W-1:0]  thr_interval
);

	logic [CFG_W-1:0] delay_q;
	logic [CFG_W-1:0] interval_q;
	logic [THR_W-1:0] thr_delay_q;
	logic [THR_W-1:0] thr_interval_q;
	logic [THR_W-1:0] wr_thr;
	reg_idx_t         idx;
	logic             wr_en;

	assign idx    = reg_idx_t'(paddr[REG_LSB]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	// ms to ns at write time, so the compare needs no divide
	assign wr_thr = THR_W'(pwdata[CFG_W-1:0]) * NS_PER_MS;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q        <= DELAY_RESET;
			interval_q     <= INTERVAL_RESET;
			thr_delay_q    <= THR_DELAY_RESET;
			thr_interval_q <= THR_INTERVAL_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_DELAY: begin
					delay_q     <= pwdata[CFG_W-1:0];
					thr_delay_q <= wr_thr;
				end
				REG_INTERVAL: begin
					interval_q     <= pwdata[CFG_W-1:0];
					thr_interval_q <= wr_thr;
				end
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_DELAY:    prdata = DATA_W'(delay_q);
			REG_INTERVAL: prdata = DATA_W'(interval_q);
			default:      prdata = '0;
		endcase
	end

	assign thr_delay    = thr_delay_q;
	assign thr_interval = thr_interval_q;

endmodule

`default_nettype wire

// ===== hdl/rkrf_front.sv =====
// Front end: registers the input transaction, classifies it against the held key state
// and pushes release/event commands. Depends on rkrf_pkg and rkrf_in_if.
`default_nettype none

module rkrf_front import rkrf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	rkrf_in_if.sink               evt,
	input  wire logic [THR_W-1:0] thr_delay,
	input  wire logic [THR_W-1:0] thr_interval,
	output cmd_t                  push_cmd,
	output logic                  push_valid,
	input  wire logic             push_ready
);

	// input stage
	logic               valid_s1;
	logic               op_s1;
	logic [KEY_W-1:0]   key_s1;
	logic               tog_s1;
	logic               rbit_s1;
	logic [STAMP_W-1:0] stamp_s1;

	// held key state
	logic [STAMP_W-1:0] press_q;
	logic [STAMP_W-1:0] accept_q;
	logic [KEY_W-1:0]   held_key_q;
	logic               held_tog_q;
	logic               rseen_q;
	logic               repeating_q;

	logic [STAMP_W-1:0] nxt_press;
	logic [STAMP_W-1:0] nxt_accept;
	logic [KEY_W-1:0]   nxt_held_key;
	logic               nxt_held_tog;
	logic               nxt_rseen;
	logic               nxt_repeating;

	logic [STAMP_W-1:0] diff_press;
	logic [STAMP_W-1:0] diff_accept;
	logic               in_delay;
	logic               in_interval;
	logic               same;
	logic               new_press;
	logic               need_push;
	logic               adv;
	cmd_t               cmd;

	assign adv       = valid_s1 && (push_ready || !need_push);
	assign evt.ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			op_s1    <= evt.op;
			key_s1   <= evt.key_code;
			tog_s1   <= evt.toggle_bit;
			rbit_s1  <= evt.repeat_bit;
			stamp_s1 <= evt.stamp_ns;
		end
	end

	// elapsed time tests; quotient < D is the same as difference < D * 1e6
	assign diff_press  = stamp_s1 - press_q;
	assign diff_accept = stamp_s1 - accept_q;
	assign in_delay    = diff_press < STAMP_W'(thr_delay);
	assign in_interval = diff_accept < STAMP_W'(thr_interval);
	assign same        = (key_s1 == held_key_q) && (tog_s1 == held_tog_q);
	assign new_press   = !same || ((rseen_q || rbit_s1) && !rbit_s1);

	// classification
	always_comb begin
		cmd           = '0;
		need_push     = 1'b0;
		nxt_press     = press_q;
		nxt_accept    = accept_q;
		nxt_held_key  = held_key_q;
		nxt_held_tog  = held_tog_q;
		nxt_rseen     = rseen_q;
		nxt_repeating = repeating_q;
		if (op_s1) begin
			// stream end: release a repeating key, forget the held code
			cmd.has_rel   = repeating_q;
			cmd.rel_key   = held_key_q;
			need_push     = repeating_q;
			nxt_repeating = 1'b0;
			nxt_held_key  = '0;
		end else begin
			nxt_rseen = rseen_q || rbit_s1;
			priority if (same && in_delay) begin
				// too soon after the press: dropped
			end else if (new_press) begin
				cmd.has_rel   = repeating_q;
				cmd.rel_key   = held_key_q;
				cmd.has_ev    = 1'b1;
				cmd.ev_key    = key_s1;
				need_push     = 1'b1;
				nxt_repeating = 1'b0;
				nxt_press     = stamp_s1;
				nxt_accept    = stamp_s1;
				nxt_held_key  = key_s1;
				nxt_held_tog  = tog_s1;
			end else if (in_interval) begin
				// repeat too close to the last accepted one: dropped
			end else begin
				cmd.has_ev    = 1'b1;
				cmd.ev_key    = key_s1;
				cmd.ev_rep    = 1'b1;
				need_push     = 1'b1;
				nxt_repeating = 1'b1;
				nxt_accept    = stamp_s1;
			end
		end
	end

	// state update when the staged transaction leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q     <= '0;
			accept_q    <= '0;
			held_key_q  <= '0;
			held_tog_q  <= 1'b0;
			rseen_q     <= 1'b0;
			repeating_q <= 1'b0;
		end else if (adv) begin
			press_q     <= nxt_press;
			accept_q    <= nxt_accept;
			held_key_q  <= nxt_held_key;
			held_tog_q  <= nxt_held_tog;
			rseen_q     <= nxt_rseen;
			repeating_q <= nxt_repeating;
		end
	end

	assign push_cmd   = cmd;
	assign push_valid = valid_s1 && need_push;

endmodule

`default_nettype wire

// ===== hdl/rkrf_queue.sv =====
// Command queue between front and back end, DEPTH entries in flip-flops.
// Depends on rkrf_pkg.
`default_nettype none

module rkrf_queue import rkrf_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t push_cmd,
	input  wire logic push_valid,
	output logic      push_ready,
	output cmd_t      pop_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rkrf_back.sv =====
// Back end: turns each command into one or two result transactions in an output register.
// Depends on rkrf_pkg and rkrf_out_if.
`default_nettype none

module rkrf_back import rkrf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t head_cmd,
	input  wire logic head_valid,
	output logic      head_pop,
	rkrf_out_if.source res
);

	logic             out_valid_q;
	logic [KEY_W-1:0] out_key_q;
	logic             is_repeat_q;
	logic             is_release_q;
	logic             last_q;
	// release of the head command already sent
	logic             rel_done_q;
	logic             load;
	logic             emit_rel;

	assign load     = !out_valid_q || res.ready;
	assign emit_rel = head_cmd.has_rel && !rel_done_q;
	assign head_pop = load && head_valid && (!emit_rel || !head_cmd.has_ev);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rel_done_q  <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				rel_done_q <= emit_rel && head_cmd.has_ev;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			if (emit_rel) begin
				out_key_q    <= head_cmd.rel_key;
				is_repeat_q  <= 1'b0;
				is_release_q <= 1'b1;
				last_q       <= !head_cmd.has_ev;
			end else begin
				out_key_q    <= head_cmd.ev_key;
				is_repeat_q  <= head_cmd.ev_rep;
				is_release_q <= 1'b0;
				last_q       <= 1'b1;
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.out_key     = out_key_q;
	assign res.is_repeat   = is_repeat_q;
	assign res.is_release  = is_release_q;
	assign res.last_of_run = last_q;

endmodule

`default_nettype wire

// ===== hdl/remote_key_repeat_filter.sv =====
// Top level of the remote key repeat filter: register file, front end, command queue, back end.
// Depends on rkrf_pkg, rkrf_in_if, rkrf_out_if, rkrf_cfg, rkrf_front, rkrf_queue, rkrf_back.
//
//  channel  dir  handshake          carries
//  evt      in   valid/ready        op, key_code, toggle_bit, repeat_bit, stamp_ns
//  res      out  valid/ready        out_key, is_repeat, is_release, last_of_run
//  apb      in   psel/penable, 0w   repeat_delay_ms @0x0, repeat_interval_ms @0x4
//
// One transaction per cycle in while the queue has room; the back end sends one result per
// cycle from its output register while res is ready, so an input that makes a release and
// a key event yields two results. Path to the first result: input stage, queue, output register.
// Reset clears all key state and queue; the registers return to 300 ms and 100 ms.
// A stalled output fills the QUEUE_DEPTH command queue, then stalls the input.
`default_nettype none

module remote_key_repeat_filter import rkrf_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	rkrf_in_if.sink                evt,
	rkrf_out_if.source             res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	logic [THR_W-1:0] thr_delay;
	logic [THR_W-1:0] thr_interval;
	cmd_t             push_cmd;
	logic             push_valid;
	logic             push_ready;
	cmd_t             head_cmd;
	logic             head_valid;
	logic             head_pop;

	rkrf_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.thr_delay    (thr_delay),
		.thr_interval (thr_interval)
	);

	rkrf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.evt          (evt),
		.thr_delay    (thr_delay),
		.thr_interval (thr_interval),
		.push_cmd     (push_cmd),
		.push_valid   (push_valid),
		.push_ready   (push_ready)
	);

	rkrf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (push_cmd),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_cmd    (head_cmd),
		.pop_valid  (head_valid),
		.pop_ready  (head_pop)
	);

	rkrf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.res        (res)
	);

endmodule

`default_nettype wire

// ===== hdl/rkrf_checker.sv =====
// Port-level checker for the remote key repeat filter, bound to the top level.
// Depends on rkrf_pkg and remote_key_repeat_filter_defines.svh.
`default_nettype none
`include "remote_key_repeat_filter_defines.svh"

module rkrf_checker import rkrf_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             evt_valid,
	input wire logic             evt_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [KEY_W-1:0] out_key,
	input wire logic             is_repeat,
	input wire logic             is_release,
	input wire logic             last_of_run
);

	logic seen_in_q;
	logic rel_pend_q;

	// an input was accepted; a release that is not last awaits its key event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_in_q  <= 1'b0;
			rel_pend_q <= 1'b0;
		end else begin
			if (evt_valid && evt_ready) begin
				seen_in_q <= 1'b1;
			end
			if (out_valid && out_ready) begin
				rel_pend_q <= is_release && !last_of_run;
			end
		end
	end

	`RKRF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_key) && $stable(is_repeat) && $stable(is_release) && $stable(last_of_run))
	`RKRF_ASSERT_IMP(a_no_result_without_input, out_valid, seen_in_q)
	`RKRF_ASSERT_IMP(a_release_then_event, out_valid && rel_pend_q, !is_release && last_of_run)
	`RKRF_ASSERT_IMP(a_repeat_is_last, out_valid && is_repeat, last_of_run && !is_release)

endmodule

bind remote_key_repeat_filter rkrf_checker u_rkrf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.evt_valid   (evt.valid),
	.evt_ready   (evt.ready),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.out_key     (res.out_key),
	.is_repeat   (res.is_repeat),
	.is_release  (res.is_release),
	.last_of_run (res.last_of_run)
);

`default_nettype wire
